[hw/rtl/owal_pkg.sv]
`timescale 1ns / 1ps

package owal_pkg;

  // Default number of CORDIC rotations.
  localparam int CORDIC_STAGES_DEF = 16;

  // Internal widths.
  localparam int CW    = 34;  // CORDIC x, y and z
  localparam int TW    = 25;  // wheel target, Q20
  localparam int BW    = 26;  // bound numerators
  localparam int MW    = 24;  // magnitudes and denominators of bounds
  localparam int NW    = 50;  // divider numerator
  localparam int DW    = 32;  // divider denominator
  localparam int QBITS = 16;  // quotient bits, one per divider stage

  // Binary angles and constants.
  localparam logic [31:0] ANG_30        = 32'd357913941;
  localparam logic [31:0] ANG_90        = 32'h4000_0000;
  localparam logic [31:0] ANG_150       = 32'd1789569707;
  localparam logic [31:0] CORDIC_X0     = 32'd652032874;
  localparam logic [15:0] ACCEL_LIM_RST = 16'h8000;

  // Per-wheel data carried through the bound stages.
  typedef struct packed {
    logic signed [BW-1:0] lo;
    logic signed [BW-1:0] hi;
    logic [MW-1:0]        d;
    logic                 tz;
    logic                 zok;
    logic signed [TW-1:0] t;
    logic signed [15:0]   me;
  } whl_t;

  typedef struct packed {
    whl_t [2:0]    w;
    logic          v_nz;
    logic          mgt;
    logic [MW-1:0] mma;
    logic [MW-1:0] mm;
  } row_t;

  // Running bounds on the scale factor, kept as fractions.
  typedef struct packed {
    logic signed [BW-1:0] hn;
    logic [MW-1:0]        hd;
    logic signed [BW-1:0] ln;
    logic [MW-1:0]        ld;
    logic                 ok;
  } bnd_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_ang(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004757;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/owal_cordic.sv]
`timescale 1ns / 1ps

module owal_cordic #(
  parameter int STAGES = owal_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        angle,
  output logic signed [31:0] sine
);
  import owal_pkg::*;

  localparam logic signed [CW-1:0] ONE_Q30 = CW'(32'h4000_0000);

  logic signed [CW-1:0] x_r [STAGES+1];
  logic signed [CW-1:0] y_r [STAGES+1];
  logic signed [CW-1:0] z_r [STAGES+1];
  logic                 f_r [STAGES+1];
  logic signed [31:0]   sin_r;
  logic                 flip_w;
  logic [31:0]          ang_w;
  logic signed [CW-1:0] yc_w;

  // Fold the second and third quadrants onto the others by a half turn.
  always_comb begin
    flip_w = angle[31] ^ angle[30];
    ang_w  = {angle[31] ^ flip_w, angle[30:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CW'(CORDIC_X0);
      y_r[0] <= '0;
      z_r[0] <= $signed({{(CW-32){ang_w[31]}}, ang_w});
      f_r[0] <= flip_w;
    end
  end

  // One rotation per stage.
  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    localparam logic signed [CW-1:0] AT = CW'(atan_ang(k));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][CW-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - AT;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + AT;
        end
        f_r[k+1] <= f_r[k];
      end
    end
  end

  // Clamp to plus or minus one and undo the fold.
  always_comb begin
    if (y_r[STAGES] > ONE_Q30) begin
      yc_w = ONE_Q30;
    end else if (y_r[STAGES] < -ONE_Q30) begin
      yc_w = -ONE_Q30;
    end else begin
      yc_w = y_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= f_r[STAGES] ? 32'(-yc_w) : 32'(yc_w);
    end
  end

  assign sine = sin_r;

endmodule

[hw/rtl/owal_div.sv]
`timescale 1ns / 1ps

module owal_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [owal_pkg::NW-1:0]  num,
  input  logic [owal_pkg::DW-1:0]  den,
  input  logic                     neg,
  output logic signed [15:0]       cmd
);
  import owal_pkg::*;

  logic [NW-1:0]    rem_r [QBITS];
  logic [DW-1:0]    den_r [QBITS];
  logic [QBITS-1:0] q_r   [QBITS];
  logic             ovf_r [QBITS];
  logic             neg_r [QBITS];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QBITS; j++) begin : g_step
    localparam int B = QBITS - 1 - j;
    logic [NW-1:0]    rin;
    logic [DW-1:0]    din;
    logic [QBITS-1:0] qin;
    logic             oin;
    logic             nin;
    logic [NW-1:0]    dsh;
    logic             ge;

    if (j == 0) begin : g_first
      always_comb begin
        rin = num;
        din = den;
        qin = '0;
        nin = neg;
        // Quotient would not fit in the quotient bits: saturate.
        oin = (num >= (NW'(den) << QBITS));
      end
    end else begin : g_next
      always_comb begin
        rin = rem_r[j-1];
        din = den_r[j-1];
        qin = q_r[j-1];
        nin = neg_r[j-1];
        oin = ovf_r[j-1];
      end
    end

    always_comb begin
      dsh = NW'(din) << B;
      ge  = (rin >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? (rin - dsh) : rin;
        den_r[j] <= din;
        q_r[j]   <= qin | (ge ? (QBITS'(1) << B) : '0);
        ovf_r[j] <= oin;
        neg_r[j] <= nin;
      end
    end
  end

  // Apply the sign and saturate to 16 bits.
  always_comb begin
    if (neg_r[QBITS-1]) begin
      if (ovf_r[QBITS-1] || (q_r[QBITS-1] > 16'd32768)) begin
        cmd = -16'sd32768;
      end else begin
        cmd = 16'(-$signed({1'b0, q_r[QBITS-1]}));
      end
    end else begin
      if (ovf_r[QBITS-1] || (q_r[QBITS-1] > 16'd32767)) begin
        cmd = 16'sd32767;
      end else begin
        cmd = q_r[QBITS-1];
      end
    end
  end

endmodule

[hw/rtl/omni_wheel_accel_limiter.sv]
`timescale 1ns / 1ps

// Throughput: one transaction per cycle while the result side does not stall; every stage is
// registered, and the CORDIC rotations and the 16-stage divider are fully pipelined.
// Reset (rst_n, synchronous, active low) clears all valid bits and sets the limit to 8.0.
// A stall on the result side holds the whole pipeline in place.
module omni_wheel_accel_limiter #(
  parameter int CORDIC_STAGES = owal_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // acceleration limit
  input  logic        in_tvalid,
  output logic        in_tready,
  // heading, drive_speed, tick_length, measured_a, measured_b, measured_c
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // command_a, command_b, command_c
  output logic        out_tuser     // decelerating
);
  import owal_pkg::*;

  localparam int CLAT = CORDIC_STAGES + 2;

  typedef struct packed {
    logic [15:0]      v;
    logic [MW-1:0]    a;
    logic [2:0][15:0] me;
  } side_t;

  logic en;

  logic [15:0] accel_lim_r;

  // Input stage.
  logic             vld0_r;
  logic [15:0]      hdg0_r;
  logic [15:0]      v0_r;
  logic [MW-1:0]    a0_r;
  logic [2:0][15:0] me0_r;
  logic [31:0]      acc_w;
  logic [31:0]      ang_w;
  logic [31:0]      angs_w [3];
  logic signed [31:0] sin_w [3];

  // Alignment with the CORDIC.
  side_t sd_r [CLAT];
  logic  vl_r [CLAT];

  // Product, target and bound set-up stages.
  logic               vlP_r;
  side_t              sdP_r;
  logic signed [47:0] p_r [3];
  logic               vlT_r;
  side_t              sdT_r;
  logic signed [TW-1:0] t_r [3];
  logic [15:0]        m_r;
  logic [15:0]        mag_w [3];
  logic [15:0]        mx_w;
  logic               vlL_r;
  row_t               rowL_r;
  row_t               rowL_nxt;

  // Bound stages, one wheel each.
  logic vlW_r [3];
  row_t rowW_r [3];
  bnd_t bnd_r [3];
  bnd_t bnd_nxt [3];

  // Feasibility, numerator and magnitude stages.
  logic               vlF_r;
  row_t               rowF_r;
  bnd_t               bndF_r;
  logic               feas_r;
  logic signed [51:0] fl_w;
  logic signed [51:0] fh_w;
  logic               vlN_r;
  logic signed [NW-1:0] n_r [3];
  logic [DW-1:0]      dn_r;
  logic               decN_r;
  logic               vlM_r;
  logic [NW-1:0]      nm_r [3];
  logic               ng_r [3];
  logic [DW-1:0]      dm_r;
  logic               decM_r;

  // Divider alignment and output register.
  logic               vlD_r [QBITS];
  logic               decD_r [QBITS];
  logic signed [15:0] cmd_w [3];
  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic               out_dec_r;

  // The pipeline advances unless a finished result is waiting.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_lim_r <= ACCEL_LIM_RST;
    end else if (cfg_we) begin
      accel_lim_r <= cfg_wdata;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r      <= 1'b0;
      vlP_r       <= 1'b0;
      vlT_r       <= 1'b0;
      vlL_r       <= 1'b0;
      vlF_r       <= 1'b0;
      vlN_r       <= 1'b0;
      vlM_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLAT; i++) begin
        vl_r[i] <= 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
        vlW_r[i] <= 1'b0;
      end
      for (int i = 0; i < QBITS; i++) begin
        vlD_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld0_r  <= in_tvalid;
      vl_r[0] <= vld0_r;
      for (int i = 1; i < CLAT; i++) begin
        vl_r[i] <= vl_r[i-1];
      end
      vlP_r    <= vl_r[CLAT-1];
      vlT_r    <= vlP_r;
      vlL_r    <= vlT_r;
      vlW_r[0] <= vlL_r;
      vlW_r[1] <= vlW_r[0];
      vlW_r[2] <= vlW_r[1];
      vlF_r    <= vlW_r[2];
      vlN_r    <= vlF_r;
      vlM_r    <= vlN_r;
      vlD_r[0] <= vlM_r;
      for (int i = 1; i < QBITS; i++) begin
        vlD_r[i] <= vlD_r[i-1];
      end
      out_valid_r <= vlD_r[QBITS-1];
    end
  end

  // Input stage: unpack and form the step limit.
  assign acc_w = accel_lim_r * in_tdata[47:32];

  always_ff @(posedge clk) begin
    if (en) begin
      hdg0_r   <= in_tdata[15:0];
      v0_r     <= in_tdata[31:16];
      a0_r     <= acc_w[31:8];
      me0_r[0] <= in_tdata[63:48];
      me0_r[1] <= in_tdata[79:64];
      me0_r[2] <= in_tdata[95:80];
    end
  end

  // Three sine evaluations: a-30deg, a+90deg (cosine), a-150deg.
  always_comb begin
    ang_w     = {hdg0_r, 16'h0000};
    angs_w[0] = ang_w - ANG_30;
    angs_w[1] = ang_w + ANG_90;
    angs_w[2] = ang_w - ANG_150;
  end

  for (genvar i = 0; i < 3; i++) begin : g_cordic
    owal_cordic #(
      .STAGES (CORDIC_STAGES)
    ) u_cordic (
      .clk   (clk),
      .en    (en),
      .angle (angs_w[i]),
      .sine  (sin_w[i])
    );
  end

  // Sideband delay line matching the CORDIC latency.
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= '{v: v0_r, a: a0_r, me: me0_r};
      for (int i = 1; i < CLAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // Speed times sine.
  always_ff @(posedge clk) begin
    if (en) begin
      sdP_r <= sd_r[CLAT-1];
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= $signed({1'b0, sd_r[CLAT-1].v}) * sin_w[i];
      end
    end
  end

  // Targets and the largest measured magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = sdP_r.me[i][15] ? (~sdP_r.me[i] + 16'd1) : sdP_r.me[i];
    end
    mx_w = mag_w[0];
    if (mag_w[1] > mx_w) begin
      mx_w = mag_w[1];
    end
    if (mag_w[2] > mx_w) begin
      mx_w = mag_w[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdT_r <= sdP_r;
      m_r   <= mx_w;
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= TW'((-p_r[i]) >>> 23);
      end
    end
  end

  // Per-wheel bounds on the scale factor and the slowing-path terms.
  always_comb begin
    logic signed [BW-1:0] ew;
    logic signed [BW-1:0] aw;
    logic [MW-1:0]        mm;
    aw = $signed({{(BW-MW){1'b0}}, sdT_r.a});
    mm = {m_r, 8'h00};
    rowL_nxt.v_nz = (sdT_r.v != 16'd0);
    rowL_nxt.mgt  = (mm > sdT_r.a);
    rowL_nxt.mma  = mm - sdT_r.a;
    rowL_nxt.mm   = mm;
    for (int i = 0; i < 3; i++) begin
      ew = $signed({{(BW-24){sdT_r.me[i][15]}}, sdT_r.me[i], 8'h00});
      rowL_nxt.w[i].t   = t_r[i];
      rowL_nxt.w[i].me  = sdT_r.me[i];
      rowL_nxt.w[i].tz  = (t_r[i] == '0);
      rowL_nxt.w[i].zok = !((ew - aw > 0) || (ew + aw < 0));
      if (!t_r[i][TW-1]) begin
        rowL_nxt.w[i].lo = ew - aw;
        rowL_nxt.w[i].hi = ew + aw;
        rowL_nxt.w[i].d  = MW'(t_r[i]);
      end else begin
        rowL_nxt.w[i].lo = -(ew + aw);
        rowL_nxt.w[i].hi = aw - ew;
        rowL_nxt.w[i].d  = MW'(-t_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rowL_r <= rowL_nxt;
    end
  end

  // Tighten the bounds one wheel per stage, comparing fractions by cross products.
  for (genvar w = 0; w < 3; w++) begin : g_bound
    bnd_t bin;
    row_t rin;
    whl_t wd;
    logic signed [51:0] ph1, ph2, pl1, pl2;

    if (w == 0) begin : g_init
      always_comb begin
        bin = '{hn: BW'(1), hd: MW'(1), ln: '0, ld: MW'(1), ok: 1'b1};
        rin = rowL_r;
      end
    end else begin : g_chain
      always_comb begin
        bin = bnd_r[w-1];
        rin = rowW_r[w-1];
      end
    end

    always_comb begin
      wd  = rin.w[w];
      ph1 = $signed(wd.hi) * $signed({1'b0, bin.hd});
      ph2 = $signed(bin.hn) * $signed({1'b0, wd.d});
      pl1 = $signed(wd.lo) * $signed({1'b0, bin.ld});
      pl2 = $signed(bin.ln) * $signed({1'b0, wd.d});
      bnd_nxt[w] = bin;
      if (wd.tz) begin
        if (!wd.zok) begin
          bnd_nxt[w].ok = 1'b0;
        end
      end else begin
        if (ph1 < ph2) begin
          bnd_nxt[w].hn = wd.hi;
          bnd_nxt[w].hd = wd.d;
        end
        if (pl1 > pl2) begin
          bnd_nxt[w].ln = wd.lo;
          bnd_nxt[w].ld = wd.d;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bnd_r[w]  <= bnd_nxt[w];
        rowW_r[w] <= rin;
      end
    end
  end

  // Joint feasibility: lower bound at or below upper bound.
  always_comb begin
    fl_w = $signed(bnd_r[2].ln) * $signed({1'b0, bnd_r[2].hd});
    fh_w = $signed(bnd_r[2].hn) * $signed({1'b0, bnd_r[2].ld});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rowF_r <= rowW_r[2];
      bndF_r <= bnd_r[2];
      feas_r <= rowW_r[2].v_nz && bnd_r[2].ok && (fl_w <= fh_w);
    end
  end

  // Numerators and the shared denominator for either path.
  always_ff @(posedge clk) begin
    if (en) begin
      decN_r <= !feas_r;
      if (feas_r) begin
        dn_r <= DW'({bndF_r.hd, 8'h00});
      end else if (rowF_r.mgt) begin
        dn_r <= DW'(rowF_r.mm);
      end else begin
        dn_r <= DW'(1);
      end
      for (int i = 0; i < 3; i++) begin
        if (feas_r) begin
          n_r[i] <= $signed(rowF_r.w[i].t) * $signed(bndF_r.hn);
        end else if (rowF_r.mgt) begin
          n_r[i] <= $signed(rowF_r.w[i].me) * $signed({1'b0, rowF_r.mma});
        end else begin
          n_r[i] <= '0;
        end
      end
    end
  end

  // Magnitude plus half the denominator, rounding half away from zero.
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r   <= dn_r;
      decM_r <= decN_r;
      for (int i = 0; i < 3; i++) begin
        ng_r[i] <= n_r[i][NW-1];
        nm_r[i] <= (n_r[i][NW-1] ? NW'(-n_r[i]) : NW'(n_r[i])) + NW'(dn_r >> 1);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    owal_div u_div (
      .clk (clk),
      .en  (en),
      .num (nm_r[i]),
      .den (dm_r),
      .neg (ng_r[i]),
      .cmd (cmd_w[i])
    );
  end

  // Path flag delayed alongside the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      decD_r[0] <= decM_r;
      for (int i = 1; i < QBITS; i++) begin
        decD_r[i] <= decD_r[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {cmd_w[2], cmd_w[1], cmd_w[0]};
      out_dec_r  <= decD_r[QBITS-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dec_r;

endmodule
